>>> sv/console_line_editor_macros.svh
// Assertion macros for the console line editor checker.
// No dependencies.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console_line_editor: assertion failed");

// Next-cycle implication, disabled during reset.
`define CLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console_line_editor: assertion failed");

`endif

>>> sv/cle_pkg.sv
// Shared types and constants for the console line editor.
// No dependencies; used by every module of the block.
`default_nettype none

package cle_pkg;

  localparam int LINE_DEPTH = 16;
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CHAR_W = 7;
  localparam int LEN_W = 5;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
  localparam logic [CHAR_W-1:0] CH_ETX = 7'h03;
  localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
  localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_DC2 = 7'h12;
  localparam logic [CHAR_W-1:0] CH_NAK = 7'h15;
  localparam logic [CHAR_W-1:0] CH_ETB = 7'h17;
  localparam logic [CHAR_W-1:0] CH_ESC = 7'h1B;
  localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERASE1,
    OP_REDRAW,
    OP_KILL,
    OP_FINISH,
    OP_ABORT
  } op_t;

  typedef struct packed {
    logic              start;
    logic              store_en;
    logic              dec_en;
    logic              clr_en;
    logic              step_en;
    op_t               op;
    logic [CHAR_W-1:0] rx;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_free;
    logic step_last;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/cle_ctrl.sv
// Controller of the console line editor: decodes the received byte and
// sequences result generation. Depends on cle_pkg.
`default_nettype none

module cle_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,
  input  wire cle_pkg::sts_t    sts,
  output cle_pkg::cmd_t         cmd
);
  import cle_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state;
  state_t            state_next;
  op_t               op;
  op_t               op_next;
  op_t               op_dec;
  logic              acc;
  logic              step;
  logic              store;
  logic              dec;
  logic              clr;
  logic [CHAR_W-1:0] rx;

  assign rx = s_tdata[CHAR_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign acc = s_tready && s_tvalid;
  assign step = (state == ST_RUN) && sts.out_free;

  always_comb begin
    op_dec = OP_NONE;
    store = 1'b0;
    dec = 1'b0;
    clr = 1'b0;
    unique case (rx)
      CH_LF, CH_CR: op_dec = OP_FINISH;
      CH_BS: begin
        if (!sts.count_zero) begin
          op_dec = OP_ERASE1;
          dec = 1'b1;
        end
      end
      CH_ETX: begin
        op_dec = OP_ABORT;
        clr = 1'b1;
      end
      CH_DC2: op_dec = OP_REDRAW;
      CH_ESC, CH_NAK, CH_ETB: begin
        if (!sts.count_zero) op_dec = OP_KILL;
      end
      CH_NUL: begin
        store = 1'b1;
        op_dec = OP_FINISH;
      end
      default: store = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    op_next = op;
    if (acc && op_dec != OP_NONE) begin
      state_next = ST_RUN;
      op_next = op_dec;
    end else if (step && sts.step_last) begin
      state_next = ST_IDLE;
      op_next = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_NONE;
    end else begin
      state <= state_next;
      op <= op_next;
    end
  end

  always_comb begin
    cmd.start = acc;
    cmd.store_en = acc && store;
    cmd.dec_en = acc && dec;
    // line empties on abort, at the end of kill and at line completion
    cmd.clr_en = (acc && clr) ||
                 (step && sts.step_last && (op == OP_KILL || op == OP_FINISH));
    cmd.step_en = step;
    cmd.op = op;
    cmd.rx = rx;
  end

endmodule

`default_nettype wire

>>> sv/cle_dp.sv
// Datapath of the console line editor: line store, count, walk counters
// and the output register. Depends on cle_pkg.
`default_nettype none

module cle_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cle_pkg::cmd_t     cmd,
  output cle_pkg::sts_t          sts,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [15:0]            m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);
  import cle_pkg::*;

  logic [CHAR_W-1:0] store [LINE_DEPTH];
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        phase;
  logic [CHAR_W-1:0] rd_data;
  logic              idx_end;

  logic [KIND_W-1:0] cur_kind;
  logic [CHAR_W-1:0] cur_data;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_ab;
  logic              cur_last;
  logic [IDX_W-1:0]  idx_next;
  logic [1:0]        phase_next;

  logic [KIND_W-1:0] o_kind;
  logic [CHAR_W-1:0] o_data;
  logic [LEN_W-1:0]  o_len;
  logic              o_ab;

  assign rd_data = store[idx];
  assign idx_end = (CNT_W'(idx) == count - CNT_W'(1));

  always_comb begin
    cur_kind = KIND_ECHO;
    cur_data = '0;
    cur_len = '0;
    cur_ab = 1'b0;
    cur_last = 1'b0;
    idx_next = idx;
    phase_next = phase;
    unique case (cmd.op)
      OP_NONE: ;
      OP_ERASE1: begin
        cur_data = (phase == 2'd1) ? CH_SP : CH_BS;
        cur_last = (phase == 2'd2);
        phase_next = phase + 2'd1;
      end
      OP_KILL: begin
        cur_data = (phase == 2'd1) ? CH_SP : CH_BS;
        cur_last = (phase == 2'd2) && idx_end;
        if (phase == 2'd2) begin
          phase_next = 2'd0;
          idx_next = idx + IDX_W'(1);
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      OP_REDRAW: begin
        if (phase == 2'd0) begin
          cur_data = CH_LF;
          phase_next = 2'd1;
        end else if (phase == 2'd1) begin
          cur_data = CH_CR;
          cur_last = (count == '0);
          phase_next = 2'd2;
        end else begin
          cur_data = rd_data;
          cur_last = idx_end;
          idx_next = idx + IDX_W'(1);
        end
      end
      OP_FINISH: begin
        if (phase == 2'd0 && count != '0) begin
          cur_kind = KIND_LINE;
          cur_data = rd_data;
          if (idx_end) phase_next = 2'd1;
          else idx_next = idx + IDX_W'(1);
        end else begin
          cur_kind = KIND_END;
          cur_len = LEN_W'(count);
          cur_last = 1'b1;
        end
      end
      OP_ABORT: begin
        cur_kind = KIND_END;
        cur_ab = 1'b1;
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    sts.count_zero = (count == '0);
    sts.out_free = !m_tvalid || m_tready;
    sts.step_last = cur_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_en && count < CNT_W'(LINE_DEPTH)) begin
      store[count[IDX_W-1:0]] <= cmd.rx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
      phase <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        count <= '0;
      end else if (cmd.dec_en) begin
        count <= count - CNT_W'(1);
      end else if (cmd.store_en && count < CNT_W'(LINE_DEPTH)) begin
        count <= count + CNT_W'(1);
      end

      if (cmd.start) begin
        idx <= '0;
        phase <= '0;
      end else if (cmd.step_en) begin
        idx <= idx_next;
        phase <= phase_next;
      end

      if (cmd.step_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      o_kind <= cur_kind;
      o_data <= cur_data;
      o_len <= cur_len;
      o_ab <= cur_ab;
      m_tlast <= cur_last;
    end
  end

  assign m_tdata = {3'b000, o_ab, o_len, o_data};
  assign m_tuser = o_kind;

endmodule

`default_nettype wire

>>> sv/console_line_editor.sv
// Console line editor top level: cle_ctrl and cle_dp, uses cle_pkg.
// The first result of an item passes the state register, then the output register.
// Results come one per cycle from the store walk while the output is free; an item
// with results holds the input until its last result is registered, one with none does not.
// Reset (rst, synchronous) empties the line; the line store itself is not cleared.
`default_nettype none

module console_line_editor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [6:0] data_byte, [11:7] line_length, [12] aborted
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast
);
  import cle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

>>> sv/cle_checker.sv
// Port-level checker for the console line editor, bound to the top level.
// Depends on cle_pkg and console_line_editor_macros.svh.
`default_nettype none
`include "console_line_editor_macros.svh"

module cle_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  import cle_pkg::*;

  logic out_stall;
  logic is_end;
  assign out_stall = m_tvalid && !m_tready;
  assign is_end = m_tvalid && (m_tuser == KIND_END);

  `CLE_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
  `CLE_ASSERT_NOW(a_end_is_last, clk, rst, is_end, m_tlast && m_tdata[6:0] == 7'd0)
  `CLE_ASSERT_NOW(a_abort_len, clk, rst, m_tvalid && m_tdata[12], is_end && m_tdata[11:7] == 5'd0)
  `CLE_ASSERT_NOW(a_byte_fields, clk, rst, m_tvalid && !is_end, m_tdata[15:7] == 9'd0)

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

`default_nettype wire

>>> sim/tb_console_line_editor.sv
`timescale 1ns / 1ps
// Testbench for console_line_editor: random console byte streams with stalls on both sides.
// Depends on cle_pkg and the console_line_editor RTL.

import cle_pkg::*;

typedef struct packed {
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] data;
  logic [LEN_W-1:0]  len;
  logic              aborted;
  logic              last;
} editor_result_t;

class echo_line_scoreboard;
  logic [CHAR_W-1:0] line_chars [LINE_DEPTH];
  int unsigned       char_count;
  editor_result_t    expected_q [$];
  int                errors;

  function new();
    char_count = 0;
    errors = 0;
  endfunction

  function void push(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] data,
                     logic [LEN_W-1:0] len, logic aborted);
    editor_result_t r;
    r.kind = kind;
    r.data = data;
    r.len = len;
    r.aborted = aborted;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function void push_erase();
    push(KIND_ECHO, CH_BS, '0, 1'b0);
    push(KIND_ECHO, CH_SP, '0, 1'b0);
    push(KIND_ECHO, CH_BS, '0, 1'b0);
  endfunction

  function void store_char(logic [CHAR_W-1:0] c);
    // full line: byte dropped without a trace
    if (char_count < LINE_DEPTH) begin
      line_chars[char_count] = c;
      char_count++;
    end
  endfunction

  function void flush_line();
    for (int i = 0; i < char_count; i++)
      push(KIND_LINE, line_chars[i], '0, 1'b0);
    push(KIND_END, '0, LEN_W'(char_count), 1'b0);
    char_count = 0;
  endfunction

  // Predict the results of one accepted console byte.
  function void note_rx(logic [7:0] rx);
    logic [CHAR_W-1:0] b;
    int                n0;
    editor_result_t    t;
    b = rx[CHAR_W-1:0];
    n0 = expected_q.size();
    case (b)
      CH_LF, CH_CR: flush_line();
      CH_BS: begin
        if (char_count > 0) begin
          char_count--;
          push_erase();
        end
      end
      CH_ETX: begin
        char_count = 0;
        push(KIND_END, '0, '0, 1'b1);
      end
      CH_DC2: begin
        push(KIND_ECHO, CH_LF, '0, 1'b0);
        push(KIND_ECHO, CH_CR, '0, 1'b0);
        for (int i = 0; i < char_count; i++)
          push(KIND_ECHO, line_chars[i], '0, 1'b0);
      end
      CH_ESC, CH_NAK, CH_ETB: begin
        for (int i = 0; i < char_count; i++)
          push_erase();
        char_count = 0;
      end
      CH_NUL: begin
        store_char(b);
        flush_line();
      end
      default: store_char(b);
    endcase
    if (expected_q.size() > n0) begin
      t = expected_q.pop_back();
      t.last = 1'b1;
      expected_q.push_back(t);
    end
  endfunction

  function void report(string field, int exp_v, int act_v);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, act_v);
    errors++;
  endfunction

  function void check_out(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
    editor_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0h data %0h tlast %0b",
               $time, tuser, tdata, tlast);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (tuser !== e.kind) report("kind", e.kind, tuser);
    if (tdata[6:0] !== e.data) report("data_byte", e.data, tdata[6:0]);
    if (tdata[11:7] !== e.len) report("line_length", e.len, tdata[11:7]);
    if (tdata[12] !== e.aborted) report("aborted", e.aborted, tdata[12]);
    if (tdata[15:13] !== 3'b000) report("tdata padding", 0, tdata[15:13]);
    if (tlast !== e.last) report("last", e.last, tlast);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_console_line_editor;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEM_TARGET = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  echo_line_scoreboard sb;
  int   items_sent;
  int   idle_cycles;
  bit   rx_hold_req;
  bit   steady;

  console_line_editor uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_rx(input logic [7:0] b);
    int g;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_code(input logic [CHAR_W-1:0] code);
    send_rx({1'($urandom_range(0, 1)), code});
  endtask

  // One typed line: printable content with some edits and noise, then a random ending or none.
  task automatic random_line(input int idx);
    logic [CHAR_W-1:0] enders [8];
    int len;
    int r;
    int pick;
    enders = '{CH_CR, CH_LF, CH_NUL, CH_ETX, CH_ESC, CH_NAK, CH_ETB, CH_DC2};
    if (idx < 2 || $urandom_range(0, 3) == 0) len = $urandom_range(16, 20);
    else len = $urandom_range(0, 8);
    for (int j = 0; j < len; j++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_code(CH_BS);
      else if (r == 1) send_code(CH_DC2);
      else if (r == 2) send_rx(8'($urandom_range(0, 255)));
      else send_code(7'($urandom_range(32, 126)));
    end
    if (idx == 0) pick = 2;
    else if (idx == 1) pick = 5;
    else pick = $urandom_range(0, 8);
    if (pick < 8) send_code(enders[pick]);
  endtask

  // handshake monitor, scoreboard hookup and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_rx(s_tdata);
      if (m_tvalid && m_tready) sb.check_out(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
        $display("tb_console_line_editor NOT OK");
        $finish;
      end
    end
  end

  // receiver: random ready with gaps, always ready in steady phases, one long hold on request
  initial begin : rx_side
    int g;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stim
    int idx;
    sb = new();
    items_sent = 0;
    idle_cycles = 0;
    rx_hold_req = 1'b0;
    steady = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    m_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-line edits, bit 7 ignored, redraw, zero byte ends the line
    send_rx({1'b0, CH_CR});
    send_rx({1'b0, CH_BS});
    send_rx({1'b1, CH_NAK});
    send_rx({1'b0, CH_DC2});
    send_rx({1'b0, CH_ETX});
    send_rx(8'hFF);
    send_rx({1'b0, CH_SP});
    send_rx({1'b0, CH_DC2});
    send_rx({1'b1, CH_BS});
    send_rx({1'b1, CH_CR});
    send_rx(8'h41);
    send_rx({1'b0, CH_NUL});
    send_rx(8'h71);
    send_rx({1'b0, CH_ESC});
    send_rx(8'h7A);
    send_rx({1'b0, CH_ETB});
    send_rx(8'h6B);
    send_rx({1'b0, CH_LF});
    send_rx(8'h6D);
    send_rx({1'b1, CH_ETX});
    send_rx({1'b1, CH_NUL});

    idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (idx == 6) begin
        // receiver holds off while redraws pile up behind it
        rx_hold_req = 1'b1;
        send_rx(8'h61);
        send_rx(8'h62);
        repeat (3) send_rx({1'b0, CH_DC2});
        send_rx({1'b0, CH_CR});
      end
      steady = (idx >= 12 && idx < 16);
      random_line(idx);
      idx++;
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_console_line_editor OK");
    end else begin
      $display("tb_console_line_editor NOT OK");
    end
    $finish;
  end

endmodule
